// File: rtl/ssr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the streaming string replace block.
// Used by ssr_ctrl, ssr_dpath and stream_string_replace; depends on nothing.

package ssr_pkg;

  localparam int MAX_LEN_DEF = 16;   // default lookahead window depth
  localparam int REG_W       = 64;   // width of the byte-holding config registers
  localparam int LEN_W       = 5;    // width of the length config registers
  localparam int HALF_BYTES  = 8;    // bytes held by one 64-bit register
  localparam int REG_BYTES   = 16;   // bytes held by a low/high register pair
  localparam int CFG_IDX_W   = 3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LOW  = 3'd0,
    REG_PATTERN_HIGH = 3'd1,
    REG_REPLACE_LOW  = 3'd2,
    REG_REPLACE_HIGH = 3'd3,
    REG_PATTERN_LEN  = 3'd4,
    REG_REPLACE_LEN  = 3'd5
  } cfg_reg_t;

  // Datapath operations issued by the controller
  typedef enum logic [2:0] {
    DP_NONE       = 3'd0,  // hold
    DP_APPEND     = 3'd1,  // store request byte in window
    DP_SHIFT      = 3'd2,  // store request byte, emit oldest, shift window
    DP_MATCH      = 3'd3,  // empty window, rewind replacement index
    DP_MATCH_MARK = 3'd4,  // empty window, emit bare end marker
    DP_REP        = 3'd5,  // emit next replacement byte
    DP_FLUSH      = 3'd6   // emit oldest window byte, shift window
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   run_last;
    logic   stream_end;
  } dp_cmd_t;

  typedef struct packed {
    logic slot_free;   // output register can take a byte this cycle
    logic full;        // window reaches pattern length with request byte
    logic match;       // window plus request byte equals pattern
    logic rep_empty;   // replacement length is zero
    logic rep_done;    // current replacement byte is the final one
    logic count_zero;  // window holds no bytes
    logic flush_done;  // window holds exactly one byte
  } dp_stat_t;

endpackage

// File: rtl/ssr_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the streaming string replace block: accepts requests and
// steps the datapath through replacement runs and flushes. Uses ssr_pkg.

module ssr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_is_last,
  output logic              in_stall,
  input  ssr_pkg::dp_stat_t stat,
  output ssr_pkg::dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_REP   = 3'b010,
    S_FLUSH = 3'b100
  } ctl_state_t;

  ctl_state_t state_r, state_nxt;
  logic       last_r, last_nxt;
  logic       accept;

  assign in_stall = !((state_r == S_IDLE) && stat.slot_free);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt      = state_r;
    last_nxt       = last_r;
    cmd.op         = ssr_pkg::DP_NONE;
    cmd.run_last   = 1'b0;
    cmd.stream_end = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          priority if (stat.full && stat.match) begin
            last_nxt = in_is_last;
            if (!stat.rep_empty) begin
              cmd.op    = ssr_pkg::DP_MATCH;
              state_nxt = S_REP;
            end else if (in_is_last) begin
              // deleted match at end of stream: nothing left, bare marker
              cmd.op         = ssr_pkg::DP_MATCH_MARK;
              cmd.run_last   = 1'b1;
              cmd.stream_end = 1'b1;
            end else begin
              cmd.op = ssr_pkg::DP_MATCH;
            end
          end else if (stat.full) begin
            // oldest byte goes out; count stays as it was before the request
            cmd.op         = ssr_pkg::DP_SHIFT;
            cmd.run_last   = !in_is_last || stat.count_zero;
            cmd.stream_end = in_is_last && stat.count_zero;
            if (in_is_last && !stat.count_zero) begin
              state_nxt = S_FLUSH;
            end
          end else begin
            cmd.op = ssr_pkg::DP_APPEND;
            if (in_is_last) begin
              state_nxt = S_FLUSH;
            end
          end
        end
      end
      S_REP: begin
        if (stat.slot_free) begin
          cmd.op = ssr_pkg::DP_REP;
          if (stat.rep_done) begin
            // window is empty after a match, so a flush adds nothing
            cmd.run_last   = 1'b1;
            cmd.stream_end = last_r;
            state_nxt      = S_IDLE;
          end
        end
      end
      S_FLUSH: begin
        if (stat.slot_free) begin
          cmd.op = ssr_pkg::DP_FLUSH;
          if (stat.flush_done) begin
            cmd.run_last   = 1'b1;
            cmd.stream_end = 1'b1;
            state_nxt      = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule

// File: rtl/ssr_dpath.sv
`timescale 1ns / 1ps
// Datapath for the streaming string replace block: config registers,
// lookahead window, pattern compare and output register. Uses ssr_pkg.

module ssr_dpath #(
  parameter int MAX_LEN = ssr_pkg::MAX_LEN_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [ssr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ssr_pkg::REG_W-1:0]       cfg_data,
  input  logic [7:0]                      in_byte,
  input  logic                            out_stall,
  input  ssr_pkg::dp_cmd_t                cmd,
  output ssr_pkg::dp_stat_t               stat,
  output logic                            out_valid,
  output logic [7:0]                      out_byte,
  output logic                            out_byte_present,
  output logic                            out_run_last,
  output logic                            out_stream_end
);

  localparam int CW  = $clog2(MAX_LEN + 1);
  localparam int IW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LCW = (CW > ssr_pkg::LEN_W) ? CW : ssr_pkg::LEN_W;

  logic [ssr_pkg::REG_W-1:0] pat_lo_r, pat_hi_r, rep_lo_r, rep_hi_r;
  logic [ssr_pkg::LEN_W-1:0] plen_reg_r, rlen_reg_r;

  logic [7:0]    win_r [MAX_LEN];
  logic [7:0]    win_nxt [MAX_LEN];
  logic [7:0]    win_app [MAX_LEN];
  logic [7:0]    win_app_sh [MAX_LEN];
  logic [7:0]    win_sh [MAX_LEN];
  logic [7:0]    pat_byte [MAX_LEN];
  logic [7:0]    rep_byte [MAX_LEN];
  logic [CW-1:0] count_r, count_nxt, idx_r, idx_nxt;
  logic [CW:0]   count_p1;

  logic [LCW-1:0] plen_w, rlen_w;
  logic [CW-1:0]  plen, rlen;
  logic           match;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_present_r, out_present_nxt;
  logic       out_run_last_r, out_stream_end_r;
  logic       emit;

  // effective lengths: pattern 0 acts as 1, both capped at window depth
  always_comb begin
    plen_w = LCW'(plen_reg_r);
    rlen_w = LCW'(rlen_reg_r);
    priority if (plen_w == '0) begin
      plen_w = LCW'(1);
    end else if (plen_w > LCW'(MAX_LEN)) begin
      plen_w = LCW'(MAX_LEN);
    end
    if (rlen_w > LCW'(MAX_LEN)) begin
      rlen_w = LCW'(MAX_LEN);
    end
    plen = plen_w[CW-1:0];
    rlen = rlen_w[CW-1:0];
  end

  // byte views of the pattern and replacement; bytes past 15 read zero
  for (genvar j = 0; j < MAX_LEN; j++) begin : g_bytes
    if (j < ssr_pkg::HALF_BYTES) begin : g_lo
      assign pat_byte[j] = pat_lo_r[8*j +: 8];
      assign rep_byte[j] = rep_lo_r[8*j +: 8];
    end else if (j < ssr_pkg::REG_BYTES) begin : g_hi
      assign pat_byte[j] = pat_hi_r[8*(j-ssr_pkg::HALF_BYTES) +: 8];
      assign rep_byte[j] = rep_hi_r[8*(j-ssr_pkg::HALF_BYTES) +: 8];
    end else begin : g_zero
      assign pat_byte[j] = 8'h00;
      assign rep_byte[j] = 8'h00;
    end
  end

  // window with the request byte placed at the fill position
  always_comb begin
    for (int j = 0; j < MAX_LEN; j++) begin
      win_app[j] = (count_r == CW'(j)) ? in_byte : win_r[j];
    end
  end

  for (genvar j = 0; j < MAX_LEN; j++) begin : g_shift
    if (j < MAX_LEN - 1) begin : g_mid
      assign win_app_sh[j] = win_app[j+1];
      assign win_sh[j]     = win_r[j+1];
    end else begin : g_end
      assign win_app_sh[j] = win_app[j];
      assign win_sh[j]     = win_r[j];
    end
  end

  always_comb begin
    match = 1'b1;
    for (int j = 0; j < MAX_LEN; j++) begin
      if ((CW'(j) < plen) && (win_app[j] != pat_byte[j])) begin
        match = 1'b0;
      end
    end
  end

  assign count_p1        = {1'b0, count_r} + (CW+1)'(1);
  assign stat.slot_free  = !out_valid_r || !out_stall;
  assign stat.full       = count_p1 >= {1'b0, plen};
  assign stat.match      = match;
  assign stat.rep_empty  = (rlen == '0);
  assign stat.rep_done   = (({1'b0, idx_r} + (CW+1)'(1)) == {1'b0, rlen});
  assign stat.count_zero = (count_r == '0);
  assign stat.flush_done = (count_r == CW'(1));

  always_comb begin
    win_nxt         = win_r;
    count_nxt       = count_r;
    idx_nxt         = idx_r;
    emit            = 1'b0;
    out_byte_nxt    = out_byte_r;
    out_present_nxt = 1'b1;
    unique case (cmd.op)
      ssr_pkg::DP_NONE: begin
      end
      ssr_pkg::DP_APPEND: begin
        win_nxt   = win_app;
        count_nxt = count_p1[CW-1:0];
      end
      ssr_pkg::DP_SHIFT: begin
        win_nxt      = win_app_sh;
        emit         = 1'b1;
        out_byte_nxt = win_app[0];
      end
      ssr_pkg::DP_MATCH: begin
        count_nxt = '0;
        idx_nxt   = '0;
      end
      ssr_pkg::DP_MATCH_MARK: begin
        count_nxt       = '0;
        emit            = 1'b1;
        out_byte_nxt    = 8'h00;
        out_present_nxt = 1'b0;
      end
      ssr_pkg::DP_REP: begin
        emit         = 1'b1;
        out_byte_nxt = rep_byte[idx_r[IW-1:0]];
        idx_nxt      = idx_r + CW'(1);
      end
      ssr_pkg::DP_FLUSH: begin
        emit         = 1'b1;
        out_byte_nxt = win_r[0];
        win_nxt      = win_sh;
        count_nxt    = count_r - CW'(1);
      end
      default: begin
      end
    endcase
    // new pattern length drops whatever the window held
    if (cfg_we && (cfg_index == ssr_pkg::REG_PATTERN_LEN)) begin
      count_nxt = '0;
    end
  end

  assign out_valid_nxt = emit || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r    <= '0;
      pat_hi_r    <= '0;
      rep_lo_r    <= '0;
      rep_hi_r    <= '0;
      plen_reg_r  <= ssr_pkg::LEN_W'(1);
      rlen_reg_r  <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          ssr_pkg::REG_PATTERN_LOW:  pat_lo_r   <= cfg_data;
          ssr_pkg::REG_PATTERN_HIGH: pat_hi_r   <= cfg_data;
          ssr_pkg::REG_REPLACE_LOW:  rep_lo_r   <= cfg_data;
          ssr_pkg::REG_REPLACE_HIGH: rep_hi_r   <= cfg_data;
          ssr_pkg::REG_PATTERN_LEN:  plen_reg_r <= cfg_data[ssr_pkg::LEN_W-1:0];
          ssr_pkg::REG_REPLACE_LEN:  rlen_reg_r <= cfg_data[ssr_pkg::LEN_W-1:0];
          default: begin
          end
        endcase
      end
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    if (emit) begin
      out_byte_r       <= out_byte_nxt;
      out_present_r    <= out_present_nxt;
      out_run_last_r   <= cmd.run_last;
      out_stream_end_r <= cmd.stream_end;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = out_byte_r;
  assign out_byte_present = out_present_r;
  assign out_run_last     = out_run_last_r;
  assign out_stream_end   = out_stream_end_r;

  // window never holds a full pattern between requests
  a_count_below_plen: assert property (@(posedge clk) disable iff (!rst_n)
    count_r < plen)
    else $error("window count reached pattern length");

  // replacement index stays inside the replacement
  a_rep_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == ssr_pkg::DP_REP) |-> (idx_r < rlen))
    else $error("replacement index out of range");

  // flush only pulls bytes that are held
  a_flush_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == ssr_pkg::DP_FLUSH) |-> (count_r != '0))
    else $error("flush from empty window");

  // a result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> stat.slot_free)
    else $error("output register overwritten while stalled");

endmodule

// File: rtl/stream_string_replace.sv
`timescale 1ns / 1ps
// Top level of the streaming string replace block: ties the sequencer
// (ssr_ctrl) to the datapath (ssr_dpath). Uses ssr_pkg.

// Streaming find-and-replace over a byte stream. Every leftmost,
// non-overlapping occurrence of the configured pattern (1 to MAX_LEN bytes)
// is replaced by the configured replacement (0 to MAX_LEN bytes; zero
// deletes). A request whose byte causes no match and no flush is taken at
// once and, once the window is full, puts one byte in the output register.
// A match with an R-byte replacement holds off further requests while the R
// bytes go out, and a request marked last with N bytes still in the window
// holds them off while the window drains; a deleted match at end of stream
// gives one bare end marker. The single output register moves one byte per
// cycle while the result side does not stall; a stall there holds requests
// off too. Writing the pattern length empties the window. The user must write
// config registers only while the block is idle; the block does not enforce it.

module stream_string_replace #(
  parameter int MAX_LEN = ssr_pkg::MAX_LEN_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // config write port
  input  logic                          cfg_we,
  input  logic [ssr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ssr_pkg::REG_W-1:0]     cfg_data,
  // input byte requests
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_byte,
  input  logic                          in_is_last,
  // result requests
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_byte,
  output logic                          out_byte_present,
  output logic                          out_run_last,
  output logic                          out_stream_end
);

  ssr_pkg::dp_cmd_t  cmd;
  ssr_pkg::dp_stat_t stat;

  // sequencer: request acceptance, replacement runs, end-of-stream flush
  ssr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_is_last (in_is_last),
    .in_stall   (in_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  // window, compare, config and output register
  ssr_dpath #(
    .MAX_LEN (MAX_LEN)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_byte          (in_byte),
    .out_stall        (out_stall),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_byte         (out_byte),
    .out_byte_present (out_byte_present),
    .out_run_last     (out_run_last),
    .out_stream_end   (out_stream_end)
  );

endmodule
